>>> rtl/olarip_pkg.sv
// Shared widths, fixed-point constants and register indexes for the open-loop angle ramp block.
`timescale 1ns / 1ps

package olarip_pkg;

  // Field widths
  localparam int DT_W       = 16;
  localparam int VOLT_W     = 16;
  localparam int OUT_V_W    = 17;
  localparam int ANGLE_BITS = 24;
  localparam int RATE_W     = 21;
  localparam int MAG_W      = 17;

  // Datapath widths: q * 0.9 fits 32 bits, times a 17-bit magnitude fits 49 bits
  localparam int QS_W       = 32;
  localparam int PROD_W     = 49;
  localparam int DIGIT_W    = 4;

  // Stream and config port widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 80;
  localparam int CFG_DATA_W  = 21;

  // Q0.16 constants
  localparam logic [VOLT_W-1:0] MAX_VOLT  = 16'd52429;
  localparam logic [VOLT_W-1:0] MIN_VOLT  = 16'd6554;
  localparam logic [VOLT_W-1:0] RAMP_STEP = 16'd131;
  localparam logic [VOLT_W-1:0] SCALE_Q16 = 16'd58982;

  // Register indexes
  typedef enum logic [0:0] {
    REG_Q_TARGET   = 1'b0,
    REG_ANGLE_RATE = 1'b1
  } cfg_index_t;

endpackage

>>> rtl/openloop_angle_ramp_inverse_park.sv
// Open-loop q-voltage ramp, table sine/cosine and inverse Park with nibble-serial products.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | elapsed_us
//  m_*      | out | m_tvalid/m_tready  | alpha_voltage, beta_voltage, angle_used, q_level
//  cfg_wr_* | in  | cfg_wr_en          | q target (0), angle_rate (1)
//
// An item passes from accept to result beat in these steps: 4 nibble steps that form q*0.9 and
// rate*elapsed, 5 nibble steps that multiply by the two table magnitudes, one step that rounds
// and loads the output register, and the idle state, in which the next beat is taken.
// The quarter-wave table read (registered) overlaps the first nibble steps.
// Synchronous reset sets the angle to zero, the level to 0.1 and both registers to zero.
// A held output beat stalls the block in its last step; no input is taken until it moves on.
`timescale 1ns / 1ps

module openloop_angle_ramp_inverse_park #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // slave stream: [15:0] elapsed_us
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [olarip_pkg::IN_TDATA_W-1:0]      s_tdata,
  // master stream: [16:0] alpha_voltage, [33:17] beta_voltage, [57:34] angle_used,
  // [73:58] q_level, [79:74] zero
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [olarip_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // configuration write port
  input  logic                                   cfg_wr_en,
  input  olarip_pkg::cfg_index_t                 cfg_wr_index,
  input  logic [olarip_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
  import olarip_pkg::*;

  localparam int ROM_N  = SINE_TABLE_DEPTH + 1;
  localparam int AW     = $clog2(ROM_N);
  localparam int MW     = ANGLE_BITS + AW;
  localparam int FW     = AW + 2;
  localparam logic [FW-1:0] D1 = FW'(SINE_TABLE_DEPTH);
  localparam logic [FW-1:0] D2 = FW'(2 * SINE_TABLE_DEPTH);
  localparam logic [FW-1:0] D3 = FW'(3 * SINE_TABLE_DEPTH);
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [2:0] SCALE_LAST   = 3'(VOLT_W / DIGIT_W - 1);
  localparam logic [2:0] PRODUCT_LAST = 3'((MAG_W + DIGIT_W - 1) / DIGIT_W - 1);
  localparam int MSH_W = ((MAG_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(64'h8000_0000);

  typedef logic [MAG_W-1:0] qsin_t [ROM_N];

  // Quarter-wave sine in Q16 by the odd degree-9 Horner form, entry n = sin(pi/2 * n/DEPTH)
  function automatic qsin_t build_qsin();
    qsin_t       r;
    logic [63:0] f;
    logic [63:0] f2;
    logic [63:0] t;
    logic [63:0] s;
    for (int n = 0; n < ROM_N; n++) begin
      if (n >= SINE_TABLE_DEPTH) begin
        r[n] = MAG_W'(65536);
      end else begin
        f  = (64'(n) << 30) / SINE_TABLE_DEPTH;
        f2 = (f * f) >> 30;
        t  = 64'd5026995 - ((f2 * 64'd172272) >> 30);
        t  = 64'd85569306 - ((f2 * t) >> 30);
        t  = 64'd693598668 - ((f2 * t) >> 30);
        t  = 64'd1686629713 - ((f2 * t) >> 30);
        s  = (f * t) >> 30;
        s  = (s + 64'd8192) >> 14;
        if (s > 64'd65536) begin
          s = 64'd65536;
        end
        r[n] = s[MAG_W-1:0];
      end
    end
    return r;
  endfunction

  localparam qsin_t QSIN = build_qsin();

  typedef enum logic [1:0] {ST_IDLE, ST_SCALE, ST_PRODUCT, ST_DONE} state_t;

  state_t                  state;
  logic [2:0]              cnt;

  logic [VOLT_W-1:0]       target;
  logic [RATE_W-1:0]       rate;
  logic [ANGLE_BITS-1:0]   angle_acc;
  logic [VOLT_W-1:0]       q_level;

  logic [ANGLE_BITS-1:0]   ang_used;
  logic [VOLT_W-1:0]       q_sh;
  logic [DT_W-1:0]         dt_sh;
  logic [QS_W-1:0]         qs;
  logic [ANGLE_BITS-1:0]   angp;
  logic [MSH_W-1:0]        mag_s_sh;
  logic [MSH_W-1:0]        mag_c_sh;
  logic                    s_neg;
  logic                    c_neg;
  logic [PROD_W-1:0]       ps;
  logic [PROD_W-1:0]       pc;
  logic [MAG_W-1:0]        rom_q;
  logic                    rom_neg;

  logic [VOLT_W:0]         q_up;
  logic [VOLT_W-1:0]       q_ramp;
  logic [ANGLE_BITS-1:0]   ang_sel;
  logic [MW-1:0]           idx_prod;
  logic [FW-1:0]           four;
  logic [1:0]              quad;
  logic [FW-1:0]           quad_base;
  logic [FW-1:0]           rem;
  logic [FW-1:0]           num;
  logic [AW-1:0]           rom_addr;
  logic [QS_W-1:0]         qs_next;
  logic [ANGLE_BITS-1:0]   rate_ext;
  logic [ANGLE_BITS-1:0]   angp_next;
  logic [PROD_W-1:0]       ps_next;
  logic [PROD_W-1:0]       pc_next;
  logic [PROD_W:0]         rnd_s;
  logic [PROD_W:0]         rnd_c;
  logic [OUT_V_W-1:0]      mag_a;
  logic [OUT_V_W-1:0]      mag_b;
  logic [OUT_V_W-1:0]      alpha_v;
  logic [OUT_V_W-1:0]      beta_v;

  assign s_tready = (state == ST_IDLE);

  // Ramp toward the target, drop straight down when above it
  always_comb begin
    q_up   = (q_level < target) ? ({1'b0, q_level} + {1'b0, RAMP_STEP}) : {1'b0, q_level};
    q_ramp = (q_up > {1'b0, target}) ? target : q_up[VOLT_W-1:0];
  end

  // Table address: sine angle on the first step, cosine (plus a quarter turn) on the second
  always_comb begin
    ang_sel  = (cnt[0]) ? (ang_used + QUARTER_TURN) : ang_used;
    idx_prod = MW'(ang_sel) * MW'(SINE_TABLE_DEPTH);
    four     = {idx_prod[MW-1:ANGLE_BITS], 2'b00};
    priority if (four >= D3) begin
      quad = 2'd3; quad_base = D3;
    end else if (four >= D2) begin
      quad = 2'd2; quad_base = D2;
    end else if (four >= D1) begin
      quad = 2'd1; quad_base = D1;
    end else begin
      quad = 2'd0; quad_base = '0;
    end
    rem      = four - quad_base;
    num      = quad[0] ? (D1 - rem) : rem;
    rom_addr = num[AW-1:0];
  end

  // Registered quarter-wave table read
  always_ff @(posedge clk) begin
    rom_q   <= QSIN[rom_addr];
    rom_neg <= quad[1];
  end

  // One nibble step of each serial product, top digit first
  always_comb begin
    rate_ext  = ANGLE_BITS'($signed(rate));
    qs_next   = {qs[QS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
              + QS_W'(SCALE_Q16) * QS_W'(q_sh[VOLT_W-1 -: DIGIT_W]);
    angp_next = {angp[ANGLE_BITS-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
              + ANGLE_BITS'(rate_ext * ANGLE_BITS'(dt_sh[DT_W-1 -: DIGIT_W]));
    ps_next   = {ps[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
              + PROD_W'(qs) * PROD_W'(mag_s_sh[MSH_W-1 -: DIGIT_W]);
    pc_next   = {pc[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
              + PROD_W'(qs) * PROD_W'(mag_c_sh[MSH_W-1 -: DIGIT_W]);
  end

  // Round to Q16 and apply signs
  always_comb begin
    rnd_s   = {1'b0, ps} + ROUND_HALF;
    rnd_c   = {1'b0, pc} + ROUND_HALF;
    mag_a   = rnd_s[PROD_W-1:32];
    mag_b   = rnd_c[PROD_W-1:32];
    alpha_v = s_neg ? (~mag_a + OUT_V_W'(1)) : mag_a;
    beta_v  = c_neg ? (~mag_b + OUT_V_W'(1)) : mag_b;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      rate   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_wr_index)
        REG_Q_TARGET: begin
          target <= (cfg_wr_data[VOLT_W-1:0] > MAX_VOLT) ? MAX_VOLT : cfg_wr_data[VOLT_W-1:0];
        end
        REG_ANGLE_RATE: begin
          rate <= cfg_wr_data[RATE_W-1:0];
        end
      endcase
    end
  end

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      m_tvalid  <= 1'b0;
      angle_acc <= '0;
      q_level   <= MIN_VOLT;
    end else begin
      // drop the valid once the beat is taken; the done step reloads it itself
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ang_used <= angle_acc;
            q_level  <= q_ramp;
            q_sh     <= q_ramp;
            dt_sh    <= s_tdata[DT_W-1:0];
            qs       <= '0;
            angp     <= '0;
            cnt      <= '0;
            state    <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          qs    <= qs_next;
          angp  <= angp_next;
          q_sh  <= {q_sh[VOLT_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          dt_sh <= {dt_sh[DT_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          // capture sine, then cosine, in the cycle after each address
          if (cnt == 3'd1) begin
            mag_s_sh <= MSH_W'(rom_q);
            s_neg    <= !rom_neg && (rom_q != '0);
          end
          if (cnt == 3'd2) begin
            mag_c_sh <= MSH_W'(rom_q);
            c_neg    <= rom_neg;
          end
          if (cnt == SCALE_LAST) begin
            cnt   <= '0;
            ps    <= '0;
            pc    <= '0;
            state <= ST_PRODUCT;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_PRODUCT: begin
          ps       <= ps_next;
          pc       <= pc_next;
          mag_s_sh <= {mag_s_sh[MSH_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          mag_c_sh <= {mag_c_sh[MSH_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          if (cnt == PRODUCT_LAST) begin
            cnt   <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_DONE: begin
          // load the beat once the output register is free, and advance the angle
          if (!m_tvalid || m_tready) begin
            m_tdata   <= {{(OUT_TDATA_W - 2*OUT_V_W - ANGLE_BITS - VOLT_W){1'b0}},
                          q_level, ang_used, beta_v, alpha_v};
            m_tvalid  <= 1'b1;
            angle_acc <= angle_acc + angp;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/olarip_checker.sv
// Port-level checks for the open-loop angle ramp block, bound to the top level.
`timescale 1ns / 1ps

module olarip_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [olarip_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import olarip_pkg::*;

  // One item at a time: an accepted beat closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again right after an accepted beat");

  // A held output beat keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output beat changed while stalled");

  // Reported level never exceeds the 0.8 limit
  a_level_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[73:58] <= MAX_VOLT))
    else $error("q level above limit");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[79:74] == 6'd0))
    else $error("nonzero padding in output beat");

endmodule

bind openloop_angle_ramp_inverse_park olarip_checker u_olarip_checker (.*);

>>> dv/tb_openloop_angle_ramp_inverse_park.sv
// Self-checking testbench for the open-loop voltage ramp and inverse Park stream block.
`timescale 1ns / 1ps

module tb_openloop_angle_ramp_inverse_park;
  import olarip_pkg::*;

  localparam int TABLE_DEPTH     = 1024;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RANDOM_PHASES   = 9;
  localparam int TICKS_PER_PHASE = 50;

  // One output beat, laid out as on m_tdata (alpha in the lowest bits)
  typedef struct packed {
    logic [5:0]            pad;
    logic [VOLT_W-1:0]     q_level;
    logic [ANGLE_BITS-1:0] angle_used;
    logic [OUT_V_W-1:0]    beta;
    logic [OUT_V_W-1:0]    alpha;
  } park_beat_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  // Directed stimulus row: a tick (value = elapsed_us) or a register write
  typedef struct packed {
    row_kind_t             kind;
    cfg_index_t            idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    park_beat_t            want;
  } plan_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_wr_en;
  cfg_index_t             cfg_wr_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;

  // Predicted block state and registers
  logic [VOLT_W-1:0]        ramp_level  = MIN_VOLT;
  logic [VOLT_W-1:0]        ramp_target = '0;
  logic [ANGLE_BITS-1:0]    phase_angle = '0;
  logic signed [RATE_W-1:0] turn_rate   = '0;

  park_beat_t expected_beats[$];
  plan_row_t  directed_plan[$];

  bit no_idle      = 1'b0;
  int ticks_sent   = 0;
  int writes_done  = 0;
  int beats_checked = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;

  openloop_angle_ramp_inverse_park dut (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Quarter-wave sine magnitude in Q16: odd polynomial, Horner steps in Q30
  function automatic logic [MAG_W-1:0] quarter_wave_sine(input longint unsigned num);
    longint unsigned f, f2, t, s;
    if (num >= TABLE_DEPTH) return 17'd65536;
    f  = (num << 30) / TABLE_DEPTH;
    f2 = (f * f) >> 30;
    t  = 64'd5026995 - ((f2 * 64'd172272) >> 30);
    t  = 64'd85569306 - ((f2 * t) >> 30);
    t  = 64'd693598668 - ((f2 * t) >> 30);
    t  = 64'd1686629713 - ((f2 * t) >> 30);
    s  = (f * t) >> 30;
    s  = (s + 64'd8192) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return s[MAG_W-1:0];
  endfunction

  // Full-turn table sine: magnitude out, returns 1 in the negative half turn
  function automatic bit table_sine(input logic [ANGLE_BITS-1:0] ang,
                                    output logic [MAG_W-1:0] mag);
    longint unsigned k, four, quad, rem;
    k    = (64'(ang) * TABLE_DEPTH) >> ANGLE_BITS;
    four = 4 * k;
    quad = four / TABLE_DEPTH;
    rem  = four - quad * TABLE_DEPTH;
    quad = quad & 64'd3;
    mag  = quad[0] ? quarter_wave_sine(TABLE_DEPTH - rem) : quarter_wave_sine(rem);
    return quad >= 2;
  endfunction

  // q * |s| * 0.9 rounded to Q16, then signed and cut to 17 bits
  function automatic logic [OUT_V_W-1:0] scale_by_09(input logic [VOLT_W-1:0] q,
                                                     input logic [MAG_W-1:0] mag,
                                                     input bit neg);
    longint unsigned p;
    p = (64'(q) * 64'(mag) * 64'(SCALE_Q16) + 64'h8000_0000) >> 32;
    if (neg) p = -p;
    return p[OUT_V_W-1:0];
  endfunction

  // Ramp, transform at the held angle, then advance the angle
  function automatic park_beat_t advance_tick(input logic [DT_W-1:0] dt);
    logic [MAG_W-1:0] smag, cmag;
    bit               sneg, cneg;
    longint           step;
    park_beat_t       beat;
    if (ramp_level < ramp_target) ramp_level = ramp_level + RAMP_STEP;
    if (ramp_level > ramp_target) ramp_level = ramp_target;
    sneg = table_sine(phase_angle, smag);
    cneg = table_sine(phase_angle + 24'h400000, cmag);
    beat.pad        = '0;
    beat.alpha      = scale_by_09(ramp_level, smag, !sneg && smag != 0);
    beat.beta       = scale_by_09(ramp_level, cmag, cneg);
    beat.angle_used = phase_angle;
    beat.q_level    = ramp_level;
    step = longint'(turn_rate) * longint'(dt);
    phase_angle = phase_angle + step[ANGLE_BITS-1:0];
    return beat;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(12, 40);
  endfunction

  // Typical tick spacing, with full-range values and both extremes mixed in
  function automatic logic [DT_W-1:0] random_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return DT_W'($urandom_range(100, 200));
    if (r < 85) return DT_W'($urandom);
    if (r < 92) return '0;
    return '1;
  endfunction

  function automatic plan_row_t tick_row(input logic [DT_W-1:0] dt);
    return plan_row_t'{ROW_TICK, REG_Q_TARGET, CFG_DATA_W'(dt), 1'b0, '0};
  endfunction

  function automatic plan_row_t reg_row(input cfg_index_t idx,
                                        input logic [CFG_DATA_W-1:0] value);
    return plan_row_t'{ROW_WRITE, idx, value, 1'b0, '0};
  endfunction

  // Drop the input, wait for all pending beats, then let the block go idle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en    <= 1'b1;
    cfg_wr_index <= idx;
    cfg_wr_data  <= data;
    case (idx)
      REG_Q_TARGET:   ramp_target = (data[VOLT_W-1:0] > MAX_VOLT) ? MAX_VOLT
                                                                   : data[VOLT_W-1:0];
      REG_ANGLE_RATE: turn_rate = data;
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one tick after an optional gap; predict on acceptance
  task automatic send_tick(input logic [DT_W-1:0] dt, input bit typed, input park_beat_t want);
    int         gap;
    park_beat_t predicted;
    gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= dt;
    do @(posedge clk); while (!s_tready);
    predicted = advance_tick(dt);
    expected_beats.push_back(typed ? want : predicted);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Output backpressure: random stalls, none while no_idle is set
  initial begin
    int hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && !no_idle && $urandom_range(0, 99) < 20) hold = idle_len();
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each output beat with the oldest prediction
  always @(posedge clk) begin
    park_beat_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h, nothing pending", m_tdata);
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (got.alpha !== want.alpha || got.beta !== want.beta ||
            got.angle_used !== want.angle_used || got.q_level !== want.q_level ||
            got.pad !== want.pad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d exp/got: alpha %0d/%0d beta %0d/%0d angle %0d/%0d q %0d/%0d pad %0d/%0d",
                     beats_checked, $signed(want.alpha), $signed(got.alpha),
                     $signed(want.beta), $signed(got.beta), want.angle_used, got.angle_used,
                     want.q_level, got.q_level, want.pad, got.pad);
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("FAIL openloop_angle_ramp_inverse_park");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] tgt, rate;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_index = REG_Q_TARGET;
    cfg_wr_data  = '0;

    // After reset the zero target pulls the level straight down to zero
    directed_plan.push_back(plan_row_t'{ROW_TICK, REG_Q_TARGET, 21'd0, 1'b1,
                                        park_beat_t'{6'd0, 16'd0, 24'd0, 17'd0, 17'd0}});
    // Target write with all bits set saturates; first ramp step at angle zero
    directed_plan.push_back(reg_row(REG_Q_TARGET, 21'h1FFFFF));
    directed_plan.push_back(plan_row_t'{ROW_TICK, REG_Q_TARGET, 21'd0, 1'b1,
                                        park_beat_t'{6'd0, 16'd131, 24'd0, 17'd118, 17'd0}});
    directed_plan.push_back(tick_row(16'hFFFF));
    // Quarter-turn steps land on the exact quarter points and wrap
    directed_plan.push_back(reg_row(REG_ANGLE_RATE, 21'h040000));
    repeat (5) directed_plan.push_back(tick_row(16'd16));
    // Rate extremes with the longest elapsed time
    directed_plan.push_back(reg_row(REG_ANGLE_RATE, 21'h0FFFFF));
    directed_plan.push_back(tick_row(16'hFFFF));
    directed_plan.push_back(tick_row(16'hFFFF));
    directed_plan.push_back(reg_row(REG_ANGLE_RATE, 21'h100000));
    directed_plan.push_back(tick_row(16'hFFFF));
    directed_plan.push_back(tick_row(16'd1));
    // Target below the level drops at once; then ramp and clamp at the target
    directed_plan.push_back(reg_row(REG_Q_TARGET, 21'd300));
    directed_plan.push_back(tick_row(16'd150));
    directed_plan.push_back(reg_row(REG_Q_TARGET, 21'd560));
    repeat (3) directed_plan.push_back(tick_row(16'd150));
    directed_plan.push_back(reg_row(REG_Q_TARGET, 21'd0));
    directed_plan.push_back(tick_row(16'd150));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_plan[i].idx, directed_plan[i].value);
      end else begin
        send_tick(directed_plan[i].value[DT_W-1:0], directed_plan[i].typed,
                  directed_plan[i].want);
      end
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          tgt  = 21'h00FFFF;
          rate = 21'h0FFFFF;
        end
        1: begin
          tgt  = '0;
          rate = 21'h100000;
        end
        2: begin
          tgt  = CFG_DATA_W'(MAX_VOLT);
          rate = '0;
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       tgt = CFG_DATA_W'($urandom);
            1:       tgt = CFG_DATA_W'($urandom_range(0, MAX_VOLT));
            default: tgt = CFG_DATA_W'($urandom_range(0, 2000));
          endcase
          case ($urandom_range(0, 2))
            0:       rate = CFG_DATA_W'($urandom);
            1:       rate = CFG_DATA_W'($urandom_range(0, 4000));
            default: rate = CFG_DATA_W'(-int'($urandom_range(1, 4000)));
          endcase
        end
      endcase
      no_idle = (ph % 3 == 2);
      settle();
      if (ph < 3 || $urandom_range(0, 3) != 0) write_reg(REG_Q_TARGET, tgt);
      if (ph < 3 || $urandom_range(0, 3) != 0) write_reg(REG_ANGLE_RATE, rate);
      repeat (TICKS_PER_PHASE) send_tick(random_elapsed(), 1'b0, '0);
    end

    // Drain and let the pipeline run dry
    s_tvalid <= 1'b0;
    no_idle = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d ticks (%0d directed rows) under %0d register writes",
             ticks_sent, directed_plan.size(), writes_done);
    $display("%0d output beats checked, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASS openloop_angle_ramp_inverse_park");
    end else begin
      $display("FAIL openloop_angle_ramp_inverse_park");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/olarip_pkg.sv
rtl/openloop_angle_ramp_inverse_park.sv
rtl/olarip_checker.sv
dv/tb_openloop_angle_ramp_inverse_park.sv
